>>> hw/rtl/lpmc_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller package
// Shared codes, item types, reset values and the pairing sine table.
// ----------------------------------------------------------------------------
package lpmc_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_BLINK    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  // Display modes; blinking is only entered through a blink request
  typedef enum logic [2:0] {
    MODE_MANUAL  = 3'd0,
    MODE_CYCLE   = 3'd1,
    MODE_BATTERY = 3'd2,
    MODE_PAIRING = 3'd3,
    MODE_BLINK   = 3'd4
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CYCLE_STEP   = 2'd0,
    CFG_BATTERY_STEP = 2'd1,
    CFG_PAIRING_STEP = 2'd2,
    CFG_IDLE_POLL    = 2'd3
  } cfg_addr_t;

  // Reset values of the step registers
  localparam logic [15:0] CYCLE_STEP_RST   = 16'd1000;
  localparam logic [15:0] BATTERY_STEP_RST = 16'd25;
  localparam logic [15:0] PAIRING_STEP_RST = 16'd30;
  localparam logic [15:0] IDLE_POLL_RST    = 16'd250;

  // Battery ramp end points
  localparam logic [7:0] RAMP_LOW  = 8'h01;
  localparam logic [7:0] RAMP_HIGH = 8'hFF;

  // Sine breathing table
  localparam int SINE_STEPS = 64;
  localparam int ROM_SIZE   = 64;
  localparam int SINE_W     = $clog2(SINE_STEPS);
  localparam int ROM_W      = $clog2(ROM_SIZE);

  localparam logic [7:0] SINE_ROM [ROM_SIZE] = '{
    8'd60, 8'd64, 8'd69, 8'd74, 8'd79, 8'd83, 8'd87, 8'd91,
    8'd95, 8'd98, 8'd101, 8'd104, 8'd106, 8'd107, 8'd109, 8'd109,
    8'd109, 8'd109, 8'd109, 8'd107, 8'd106, 8'd104, 8'd101, 8'd98,
    8'd95, 8'd91, 8'd87, 8'd83, 8'd79, 8'd74, 8'd69, 8'd64,
    8'd60, 8'd55, 8'd50, 8'd45, 8'd40, 8'd36, 8'd32, 8'd28,
    8'd24, 8'd21, 8'd18, 8'd15, 8'd13, 8'd12, 8'd10, 8'd10,
    8'd10, 8'd10, 8'd10, 8'd12, 8'd13, 8'd15, 8'd18, 8'd21,
    8'd24, 8'd28, 8'd32, 8'd36, 8'd40, 8'd45, 8'd50, 8'd54
  };

  // One input beat
  typedef struct packed {
    op_t         op;
    logic [1:0]  mode_request;
    logic [7:0]  blink_count;
    logic [15:0] blink_period_ms;
    logic [7:0]  blink_red;
    logic [7:0]  blink_green;
    logic [7:0]  blink_blue;
  } item_t;

  // Step times from the configuration registers
  typedef struct packed {
    logic [15:0] cycle_step_ms;
    logic [15:0] low_battery_step_ms;
    logic [15:0] pairing_step_ms;
    logic [15:0] idle_poll_ms;
  } cfg_t;

  // Countdown load for a step time; zero behaves like one
  function automatic logic [15:0] arm_wait(input logic [15:0] ticks);
    return (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
  endfunction

endpackage

>>> hw/rtl/lpmc_if.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------
interface lpmc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  mode_request;
  logic [7:0]  blink_count;
  logic [15:0] blink_period_ms;
  logic [7:0]  blink_red;
  logic [7:0]  blink_green;
  logic [7:0]  blink_blue;

  modport source (
    output valid, op, mode_request, blink_count, blink_period_ms,
           blink_red, blink_green, blink_blue,
    input  ready
  );
  modport sink (
    input  valid, op, mode_request, blink_count, blink_period_ms,
           blink_red, blink_green, blink_blue,
    output ready
  );
endinterface

interface lpmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic       led_written;
  logic [2:0] mode_now;

  modport source (
    output valid, led_red, led_green, led_blue, led_written, mode_now,
    input  ready
  );
  modport sink (
    input  valid, led_red, led_green, led_blue, led_written, mode_now,
    output ready
  );
endinterface

interface lpmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> hw/rtl/lpmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller configuration registers
// Holds the four step times, written through the configuration channel.
// ----------------------------------------------------------------------------
module lpmc_cfg_regs
  import lpmc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  lpmc_cfg_if.sink       cfg_ch,
  output cfg_t           cfg
);

  cfg_t cfg_r;

  // Always take a write beat
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Decode the register index and store the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_step_ms       <= CYCLE_STEP_RST;
      cfg_r.low_battery_step_ms <= BATTERY_STEP_RST;
      cfg_r.pairing_step_ms     <= PAIRING_STEP_RST;
      cfg_r.idle_poll_ms        <= IDLE_POLL_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_addr_t'(cfg_ch.addr))
        CFG_CYCLE_STEP:   cfg_r.cycle_step_ms       <= cfg_ch.data;
        CFG_BATTERY_STEP: cfg_r.low_battery_step_ms <= cfg_ch.data;
        CFG_PAIRING_STEP: cfg_r.pairing_step_ms     <= cfg_ch.data;
        CFG_IDLE_POLL:    cfg_r.idle_poll_ms        <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/lpmc_in_stage.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller input register
// Captures one command beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module lpmc_in_stage
  import lpmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lpmc_in_if.sink   in_ch,
  input  logic      take,
  output logic      item_valid,
  output item_t     item
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op              <= op_t'(in_ch.op);
      item_r.mode_request    <= in_ch.mode_request;
      item_r.blink_count     <= in_ch.blink_count;
      item_r.blink_period_ms <= in_ch.blink_period_ms;
      item_r.blink_red       <= in_ch.blink_red;
      item_r.blink_green     <= in_ch.blink_green;
      item_r.blink_blue      <= in_ch.blink_blue;
    end
  end

endmodule

>>> hw/rtl/lpmc_core.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller core
// Mode state, step countdown, pattern generators and the result register.
// ----------------------------------------------------------------------------
module lpmc_core
  import lpmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       take,
  lpmc_out_if.source out_ch
);

  // Mode and pattern state
  mode_t             active_mode_r, active_mode_nxt;
  logic [1:0]        saved_mode_r, saved_mode_nxt;
  logic [15:0]       wait_left_r, wait_left_nxt;
  logic [8:0]        phases_left_r, phases_left_nxt;
  logic [15:0]       half_period_r, half_period_nxt;
  logic [23:0]       blink_color_r, blink_color_nxt;
  logic [7:0]        battery_level_r, battery_level_nxt;
  logic              ramp_rising_r, ramp_rising_nxt;
  logic [1:0]        cycle_index_r, cycle_index_nxt;
  logic [SINE_W-1:0] sine_phase_r, sine_phase_nxt;
  logic [23:0]       shown_color_r, shown_color_nxt;

  // Result register
  logic              out_valid_r;
  logic [23:0]       out_color_r;
  logic              out_written_r;
  mode_t             out_mode_r;

  // Step scratch values
  mode_t             step_mode;
  logic              written;
  logic [1:0]        cyc;
  logic              rising;
  logic [SINE_W-1:0] ph;
  logic [ROM_W-1:0]  rom_idx;
  logic [7:0]        sine_val;

  // Consume the held beat when the result slot is free or draining
  assign take = item_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_red     = out_color_r[23:16];
  assign out_ch.led_green   = out_color_r[15:8];
  assign out_ch.led_blue    = out_color_r[7:0];
  assign out_ch.led_written = out_written_r;
  assign out_ch.mode_now    = out_mode_r;

  // Next state for one beat
  always_comb begin
    active_mode_nxt   = active_mode_r;
    saved_mode_nxt    = saved_mode_r;
    wait_left_nxt     = wait_left_r;
    phases_left_nxt   = phases_left_r;
    half_period_nxt   = half_period_r;
    blink_color_nxt   = blink_color_r;
    battery_level_nxt = battery_level_r;
    ramp_rising_nxt   = ramp_rising_r;
    cycle_index_nxt   = cycle_index_r;
    sine_phase_nxt    = sine_phase_r;
    shown_color_nxt   = shown_color_r;
    written           = 1'b0;
    step_mode         = active_mode_r;

    // Pattern helpers
    cyc      = (cycle_index_r > 2'd2) ? 2'd0 : cycle_index_r;
    rising   = (battery_level_r == RAMP_LOW)  ? 1'b1 :
               (battery_level_r == RAMP_HIGH) ? 1'b0 : ramp_rising_r;
    ph       = ({1'b0, sine_phase_r} >= (SINE_W + 1)'(SINE_STEPS)) ? '0 : sine_phase_r;
    rom_idx  = ROM_W'((32'(ph) * ROM_SIZE) / SINE_STEPS);
    sine_val = SINE_ROM[rom_idx];

    unique case (item.op)
      OP_TICK: begin
        if (wait_left_r != 16'd0) begin
          wait_left_nxt = wait_left_r - 16'd1;
        end else begin
          // Finished blink falls back to the saved mode on this boundary
          if (active_mode_r == MODE_BLINK && phases_left_r == 9'd0) begin
            step_mode = mode_t'({1'b0, saved_mode_r});
          end
          active_mode_nxt = step_mode;
          written         = (step_mode != MODE_MANUAL);
          case (step_mode)
            MODE_CYCLE: begin
              case (cyc)
                2'd0:    shown_color_nxt = 24'hFF0000;
                2'd1:    shown_color_nxt = 24'h00FF00;
                default: shown_color_nxt = 24'h0000FF;
              endcase
              cycle_index_nxt = (cyc == 2'd2) ? 2'd0 : cyc + 2'd1;
              wait_left_nxt   = arm_wait(cfg.cycle_step_ms);
            end
            MODE_BATTERY: begin
              ramp_rising_nxt   = rising;
              battery_level_nxt = rising ? {battery_level_r[6:0], 1'b1}
                                         : {1'b0, battery_level_r[7:1]};
              shown_color_nxt   = {battery_level_nxt, 16'h0000};
              wait_left_nxt     = arm_wait(cfg.low_battery_step_ms);
            end
            MODE_PAIRING: begin
              shown_color_nxt = {8'h00, 1'b0, sine_val[7:1], sine_val};
              sine_phase_nxt  = (ph == SINE_W'(SINE_STEPS - 1)) ? '0 : ph + 1'b1;
              wait_left_nxt   = arm_wait(cfg.pairing_step_ms);
            end
            MODE_BLINK: begin
              shown_color_nxt = phases_left_r[0] ? 24'h000000 : blink_color_r;
              phases_left_nxt = phases_left_r - 9'd1;
              wait_left_nxt   = arm_wait(half_period_r);
            end
            default: begin
              wait_left_nxt = arm_wait(cfg.idle_poll_ms);
            end
          endcase
        end
      end
      OP_SET_MODE: begin
        if (active_mode_r != MODE_BLINK) begin
          active_mode_nxt = mode_t'({1'b0, item.mode_request});
        end
      end
      OP_BLINK: begin
        if (active_mode_r != MODE_BLINK) begin
          saved_mode_nxt  = active_mode_r[1:0];
          active_mode_nxt = MODE_BLINK;
          phases_left_nxt = {item.blink_count, 1'b0};
          half_period_nxt = {1'b0, item.blink_period_ms[15:1]};
          blink_color_nxt = {item.blink_red, item.blink_green, item.blink_blue};
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_mode_r   <= MODE_MANUAL;
      saved_mode_r    <= 2'd0;
      wait_left_r     <= 16'd0;
      phases_left_r   <= 9'd0;
      half_period_r   <= 16'd0;
      blink_color_r   <= 24'h000000;
      battery_level_r <= RAMP_LOW;
      ramp_rising_r   <= 1'b1;
      cycle_index_r   <= 2'd0;
      sine_phase_r    <= '0;
      shown_color_r   <= 24'h000000;
      out_valid_r     <= 1'b0;
    end else begin
      if (take) begin
        active_mode_r   <= active_mode_nxt;
        saved_mode_r    <= saved_mode_nxt;
        wait_left_r     <= wait_left_nxt;
        phases_left_r   <= phases_left_nxt;
        half_period_r   <= half_period_nxt;
        blink_color_r   <= blink_color_nxt;
        battery_level_r <= battery_level_nxt;
        ramp_rising_r   <= ramp_rising_nxt;
        cycle_index_r   <= cycle_index_nxt;
        sine_phase_r    <= sine_phase_nxt;
        shown_color_r   <= shown_color_nxt;
      end
      // Hold the result until the receiver takes the beat
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_color_r   <= shown_color_nxt;
      out_written_r <= written;
      out_mode_r    <= active_mode_nxt;
    end
  end

endmodule

>>> hw/rtl/led_pattern_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// LED pattern mode controller
// Drives one RGB LED color from 1 ms ticks, mode commands and blink requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per tick, set-mode command or one-shot blink request.
//   out_ch : one beat per input beat, in order: the LED color now shown,
//            whether this beat wrote a new color, and the active mode
//            (4 while blinking).
//   cfg_ch : writes the four step times (addr 0 cycle, 1 low battery,
//            2 pairing, 3 manual poll); always ready, write only when idle.
// An input beat passes through the input register, then through the mode
// logic into the result register.
// The block takes one beat per cycle while out_ch is not stalled.
// When out_ch stalls, the result register and the input register each hold
// one beat, then in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) selects manual mode with the LED off,
// clears both registers and loads the default step times.
// ----------------------------------------------------------------------------
module led_pattern_mode_controller_unit
  import lpmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lpmc_in_if.sink    in_ch,
  lpmc_out_if.source out_ch,
  lpmc_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  // Step time registers
  lpmc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Command input register
  lpmc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Mode logic and result register
  lpmc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern mode controller testbench
// Drives ticks, mode commands and blink requests through the valid/ready
// channels under random idling and stalls. It tracks the expected LED color,
// write flag and mode for every command beat, and checks each result beat
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lpmc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // One result beat as the checker sees it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       written;
    logic [2:0] mode;
  } led_result_t;

  // Track the controller state and hold the colors still owed by the block
  class led_color_board;
    mode_t       active_mode;
    logic [1:0]  saved_mode;
    logic [15:0] wait_left;
    logic [8:0]  phases_left;
    logic [15:0] half_period;
    logic [23:0] blink_rgb;
    logic [7:0]  level;
    bit          rising;
    logic [1:0]  cycle_idx;
    logic [5:0]  sine_phase;
    logic [23:0] shown_rgb;
    cfg_t        steps;
    led_result_t pending_colors[$];
    int          errors;

    function new();
      active_mode = MODE_MANUAL;
      saved_mode  = 2'd0;
      wait_left   = 16'd0;
      phases_left = 9'd0;
      half_period = 16'd0;
      blink_rgb   = 24'd0;
      level       = RAMP_LOW;
      rising      = 1'b1;
      cycle_idx   = 2'd0;
      sine_phase  = '0;
      shown_rgb   = 24'd0;
      steps       = '{CYCLE_STEP_RST, BATTERY_STEP_RST, PAIRING_STEP_RST, IDLE_POLL_RST};
      errors      = 0;
    endfunction

    // A step time of zero behaves like one tick
    function logic [15:0] countdown_from(logic [15:0] ticks);
      return (ticks > 16'd0) ? ticks - 16'd1 : 16'd0;
    endfunction

    function void set_step(cfg_addr_t idx, logic [15:0] val);
      case (idx)
        CFG_CYCLE_STEP:   steps.cycle_step_ms = val;
        CFG_BATTERY_STEP: steps.low_battery_step_ms = val;
        CFG_PAIRING_STEP: steps.pairing_step_ms = val;
        default:          steps.idle_poll_ms = val;
      endcase
    endfunction

    // Advance the state by one accepted command beat and queue its result
    function void note_beat(item_t it);
      led_result_t r;
      logic [7:0]  v;
      r.written = 1'b0;
      case (it.op)
        OP_TICK: begin
          if (wait_left != 16'd0) begin
            wait_left = wait_left - 16'd1;
          end else begin
            // finished blink hands the boundary back to the saved mode
            if (active_mode == MODE_BLINK && phases_left == 9'd0)
              active_mode = mode_t'({1'b0, saved_mode});
            case (active_mode)
              MODE_CYCLE: begin
                case (cycle_idx)
                  2'd0:    shown_rgb = 24'hFF0000;
                  2'd1:    shown_rgb = 24'h00FF00;
                  default: shown_rgb = 24'h0000FF;
                endcase
                cycle_idx = (cycle_idx >= 2'd2) ? 2'd0 : cycle_idx + 2'd1;
                wait_left = countdown_from(steps.cycle_step_ms);
              end
              MODE_BATTERY: begin
                if (level == RAMP_LOW) rising = 1'b1;
                else if (level == RAMP_HIGH) rising = 1'b0;
                level = rising ? {level[6:0], 1'b1} : {1'b0, level[7:1]};
                shown_rgb = {level, 16'h0000};
                wait_left = countdown_from(steps.low_battery_step_ms);
              end
              MODE_PAIRING: begin
                v = SINE_ROM[sine_phase];
                shown_rgb = {8'h00, 1'b0, v[7:1], v};
                sine_phase = sine_phase + 1'b1;
                wait_left = countdown_from(steps.pairing_step_ms);
              end
              MODE_BLINK: begin
                // even count shows the color, odd count shows off
                shown_rgb = phases_left[0] ? 24'd0 : blink_rgb;
                phases_left = phases_left - 9'd1;
                wait_left = countdown_from(half_period);
              end
              default: wait_left = countdown_from(steps.idle_poll_ms);
            endcase
            r.written = (active_mode != MODE_MANUAL);
          end
        end
        OP_SET_MODE: begin
          if (active_mode != MODE_BLINK)
            active_mode = mode_t'({1'b0, it.mode_request});
        end
        OP_BLINK: begin
          if (active_mode != MODE_BLINK) begin
            saved_mode  = active_mode[1:0];
            active_mode = MODE_BLINK;
            phases_left = {it.blink_count, 1'b0};
            half_period = {1'b0, it.blink_period_ms[15:1]};
            blink_rgb   = {it.blink_red, it.blink_green, it.blink_blue};
          end
        end
        default: ;
      endcase
      r.red   = shown_rgb[23:16];
      r.green = shown_rgb[15:8];
      r.blue  = shown_rgb[7:0];
      r.mode  = active_mode;
      pending_colors.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed color
    function void check_beat(led_result_t got);
      led_result_t want;
      if (pending_colors.size() == 0) begin
        $error("result beat with no command waiting");
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      if (got.red !== want.red) begin
        $error("led_red: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("led_green: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("led_blue: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.written !== want.written) begin
        $error("led_written: expected %0d, actual %0d", want.written, got.written);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode_now: expected %0d, actual %0d", want.mode, got.mode);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   in_gap_pct = 21;
  int   out_stall_pct = 21;
  int   quiet_cycles = 0;
  led_color_board colors = new();

  lpmc_in_if  in_ch();
  lpmc_out_if out_ch();
  lpmc_cfg_if cfg_ch();

  led_pattern_mode_controller_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= out_stall_pct);
  end

  // Sample beats on the rising edge; watchdog on cycles with no beat at all
  always @(posedge clk) begin
    item_t       seen;
    led_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.op              = op_t'(in_ch.op);
        seen.mode_request    = in_ch.mode_request;
        seen.blink_count     = in_ch.blink_count;
        seen.blink_period_ms = in_ch.blink_period_ms;
        seen.blink_red       = in_ch.blink_red;
        seen.blink_green     = in_ch.blink_green;
        seen.blink_blue      = in_ch.blink_blue;
        colors.note_beat(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.led_red, out_ch.led_green, out_ch.led_blue,
                out_ch.led_written, out_ch.mode_now};
        colors.check_beat(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic item_t make_beat(op_t op, logic [1:0] mode, logic [7:0] count,
                                      logic [15:0] period, logic [23:0] rgb);
    item_t it;
    it.op              = op;
    it.mode_request    = mode;
    it.blink_count     = count;
    it.blink_period_ms = period;
    {it.blink_red, it.blink_green, it.blink_blue} = rgb;
    return it;
  endfunction

  // Mostly ticks so the modes get to step; rare long blinks use short halves
  function automatic item_t random_beat(bit wide_periods);
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    it.op = (pick < 66) ? OP_TICK : (pick < 80) ? OP_SET_MODE :
            (pick < 93) ? OP_BLINK : OP_NOP;
    it.mode_request = 2'($urandom_range(3));
    if ($urandom_range(39) == 0) begin
      it.blink_count     = 8'($urandom);
      it.blink_period_ms = 16'($urandom_range(1));
    end else begin
      it.blink_count     = 8'($urandom_range(4));
      it.blink_period_ms = wide_periods ? 16'($urandom) : 16'($urandom_range(9));
    end
    it.blink_red   = 8'($urandom);
    it.blink_green = 8'($urandom);
    it.blink_blue  = 8'($urandom);
    return it;
  endfunction

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_beat(item_t it);
    while ($urandom_range(99) < in_gap_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.op              = it.op;
    in_ch.mode_request    = it.mode_request;
    in_ch.blink_count     = it.blink_count;
    in_ch.blink_period_ms = it.blink_period_ms;
    in_ch.blink_red       = it.blink_red;
    in_ch.blink_green     = it.blink_green;
    in_ch.blink_blue      = it.blink_blue;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (colors.pending_colors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(cfg_addr_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = idx;
    cfg_ch.data  = val;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    colors.set_step(idx, val);
  endtask

  task automatic program_steps(logic [15:0] cyc, logic [15:0] bat,
                               logic [15:0] pair, logic [15:0] poll);
    wait_drained();
    write_step(CFG_CYCLE_STEP, cyc);
    write_step(CFG_BATTERY_STEP, bat);
    write_step(CFG_PAIRING_STEP, pair);
    write_step(CFG_IDLE_POLL, poll);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Random run; pause midway until the block has caught up
  task automatic run_random(int count, bit wide_periods);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_beat(random_beat(wide_periods));
    end
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.op              = OP_NOP;
    in_ch.mode_request    = 2'd0;
    in_ch.blink_count     = 8'd0;
    in_ch.blink_period_ms = 16'd0;
    in_ch.blink_red       = 8'd0;
    in_ch.blink_green     = 8'd0;
    in_ch.blink_blue      = 8'd0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.addr           = CFG_CYCLE_STEP;
    cfg_ch.data           = 16'd0;
    out_ch.ready          = 1'b0;
    rst_n                 = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed pass: every tick is a step boundary
    program_steps(16'd1, 16'd1, 16'd1, 16'd1);
    send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h000000));
    send_beat(make_beat(OP_NOP, 2'd3, 8'hFF, 16'hFFFF, 24'hFFFFFF));
    send_beat(make_beat(OP_SET_MODE, 2'(MODE_CYCLE), 8'd0, 16'd0, 24'h0));
    repeat (3) send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_SET_MODE, 2'(MODE_BATTERY), 8'd0, 16'd0, 24'h0));
    repeat (2) send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_SET_MODE, 2'(MODE_PAIRING), 8'd0, 16'd0, 24'h0));
    repeat (2) send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    // zero-count blink gives the mode back at the next boundary
    send_beat(make_beat(OP_BLINK, 2'd0, 8'd0, 16'd0, 24'h000000));
    send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    // commands during a blink are dropped
    send_beat(make_beat(OP_BLINK, 2'd1, 8'd2, 16'd3, 24'hFF00AA));
    send_beat(make_beat(OP_SET_MODE, 2'(MODE_MANUAL), 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_BLINK, 2'd2, 8'd5, 16'd8, 24'h123456));
    repeat (5) send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_SET_MODE, 2'(MODE_MANUAL), 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));
    send_beat(make_beat(OP_BLINK, 2'd3, 8'hFF, 16'd1, 24'hFFFFFF));

    // Zero step times act like one tick
    program_steps(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(250, 1'b0);

    // Long stretch with no idling on either side
    in_gap_pct    = 0;
    out_stall_pct = 0;
    program_steps(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
    run_random(300, 1'b0);
    in_gap_pct    = 21;
    out_stall_pct = 21;

    program_steps(16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)),
                  16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)));
    run_random(300, 1'b0);
    program_steps(16'd3, 16'd1, 16'd2, 16'd5);
    run_random(300, 1'b0);
    program_steps(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
    run_random(300, 1'b0);

    // Longest step times and full-range blink periods last
    program_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(90, 1'b1);
    send_beat(make_beat(OP_BLINK, 2'd0, 8'hFF, 16'hFFFF, 24'h00FF00));
    repeat (5) send_beat(make_beat(OP_TICK, 2'd0, 8'd0, 16'd0, 24'h0));

    wait_drained();
    if (colors.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
